// ----- hw/rtl/prrp_pkg.sv -----
// prrp_pkg: shared types, constants and codes for the ring record parser
// no dependencies; imported by every rtl file of the block except prrp_ram

package prrp_pkg;

  // stack capture depth and derived widths
  localparam int MAX_STACK_DEPTH = 32;
  localparam int STK_AW = (MAX_STACK_DEPTH > 1) ? $clog2(MAX_STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_STACK_DEPTH + 1);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BUSY_W = $clog2(QUEUE_DEPTH + 2);

  // field widths
  localparam int WORD_W = 64;
  localparam int SIZE_W = 16;
  localparam int POS_W = 13;
  localparam int SAMPLES_W = 32;
  localparam int DEPTH_W = 6;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 1;

  // record layout
  localparam logic [31:0] TYPE_SAMPLE = 32'd9;
  localparam logic [31:0] TYPE_LOST = 32'd2;
  localparam logic [SIZE_W-1:0] MIN_RECORD_BYTES = 16'd8;
  localparam logic [POS_W-1:0] IP_POS = 13'd1;
  localparam logic [POS_W-1:0] LOST_POS = 13'd2;
  localparam logic [POS_W-1:0] NR_POS = 13'd4;
  localparam logic [POS_W-1:0] CHAIN_POS = 13'd5;

  // config register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_BYTES = 1'b1;
  localparam logic [WORD_W-1:0] CONTEXT_LIMIT_RST = 64'hFFFF_FFFF_FFFF_F001;
  localparam logic [SIZE_W-1:0] MAX_RECORD_BYTES_RST = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_STACK  = 2'd0,
    KIND_TOTALS = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e_t;

  typedef enum logic [1:0] {
    CLASS_OTHER  = 2'd0,
    CLASS_SAMPLE = 2'd1,
    CLASS_LOST   = 2'd2
  } class_e_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_STACK,
    BK_IP,
    BK_ERR,
    BK_TOT
  } back_state_t;

  // one queued job: every result caused by one input word
  typedef struct packed {
    logic [CNT_W-1:0]     stack_cnt;
    logic                 ip_only;
    logic [WORD_W-1:0]    ip;
    logic                 err;
    logic                 tot;
    logic [SAMPLES_W-1:0] samples;
    logic [WORD_W-1:0]    lost;
  } job_t;

  // stack store write from the front
  typedef struct packed {
    logic              en;
    logic [STK_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } stk_wr_t;

endpackage

// ----- hw/rtl/prrp_if.sv -----
// prrp_if: valid/ready channel interfaces for input words and result items
// depends on prrp_pkg

interface prrp_in_if;
  import prrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              batch_end;

  modport source (output valid, output word, output batch_end, input ready);
  modport sink (input valid, input word, input batch_end, output ready);
endinterface

interface prrp_out_if;
  import prrp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [WORD_W-1:0]    address;
  logic [DEPTH_W-1:0]   depth_index;
  logic                 last;
  logic [SAMPLES_W-1:0] samples_total;
  logic [WORD_W-1:0]    lost_total;

  modport source (output valid, output kind, output address, output depth_index,
                  output last, output samples_total, output lost_total, input ready);
  modport sink (input valid, input kind, input address, input depth_index,
                input last, input samples_total, input lost_total, output ready);
endinterface

// ----- hw/rtl/prrp_ram.sv -----
// prrp_ram: generic single write port ram with registered read
// no dependencies

module prrp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- hw/rtl/prrp_front.sv -----
// prrp_front: accepts stream words, tracks record state, writes the stack store
// and builds one job per word that has results; depends on prrp_pkg, prrp_if

module prrp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  prrp_in_if.sink                        in_ch,
  input  logic                           cfg_we,
  input  logic [prrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prrp_pkg::WORD_W-1:0]    cfg_data,
  input  logic                           q_full,
  input  logic                           stack_done,
  output logic                           push,
  output prrp_pkg::job_t                 push_job,
  output prrp_pkg::stk_wr_t              stk_wr
);
  import prrp_pkg::*;

  logic                 discard_r, discard_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     words_r, words_nxt;
  class_e_t             class_r, class_nxt;
  logic [WORD_W-1:0]    ip_r, ip_nxt;
  logic [WORD_W-1:0]    exp_r, exp_nxt;
  logic [POS_W-1:0]     seen_r, seen_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SAMPLES_W-1:0] samples_r, samples_nxt;
  logic [WORD_W-1:0]    lost_r, lost_nxt;
  logic [WORD_W-1:0]    limit_r;
  logic [SIZE_W-1:0]    max_r;
  logic [BUSY_W-1:0]    busy_r, busy_nxt;

  logic              in_ready;
  logic              accept;
  logic              chain_word;
  logic [SIZE_W-1:0] size;
  logic              finish;
  logic              stack_push;

  // a chain word may write the stack store only while no stack job is queued or being drained
  assign chain_word = !discard_r && (pos_r >= CHAIN_POS) && (class_r == CLASS_SAMPLE);
  assign in_ready = !q_full && !(chain_word && (busy_r != '0));
  assign in_ch.ready = in_ready;
  assign accept = in_ch.valid && in_ready;
  assign size = in_ch.word[WORD_W-1:WORD_W-SIZE_W];

  // record parsing for one accepted word
  always_comb begin
    discard_nxt = discard_r;
    pos_nxt = pos_r;
    words_nxt = words_r;
    class_nxt = class_r;
    ip_nxt = ip_r;
    exp_nxt = exp_r;
    seen_nxt = seen_r;
    cnt_nxt = cnt_r;
    samples_nxt = samples_r;
    lost_nxt = lost_r;
    finish = 1'b0;
    stk_wr = '0;
    push_job = '0;
    if (accept) begin
      if (discard_r) begin
        if (in_ch.batch_end) begin
          discard_nxt = 1'b0;
        end
      end else if (pos_r == '0) begin
        // header word
        if (size < MIN_RECORD_BYTES || size > max_r) begin
          push_job.err = 1'b1;
          if (!in_ch.batch_end) begin
            discard_nxt = 1'b1;
          end
        end else begin
          words_nxt = size[SIZE_W-1:3];
          if (in_ch.word[31:0] == TYPE_SAMPLE) begin
            class_nxt = CLASS_SAMPLE;
          end else if (in_ch.word[31:0] == TYPE_LOST) begin
            class_nxt = CLASS_LOST;
          end else begin
            class_nxt = CLASS_OTHER;
          end
          ip_nxt = '0;
          exp_nxt = '0;
          seen_nxt = '0;
          cnt_nxt = '0;
          pos_nxt = IP_POS;
          finish = (size[SIZE_W-1:3] == IP_POS);
        end
      end else begin
        // body word
        if (class_r == CLASS_SAMPLE) begin
          if (pos_r == IP_POS) begin
            ip_nxt = in_ch.word;
          end else if (pos_r == NR_POS) begin
            exp_nxt = in_ch.word;
          end else if (pos_r >= CHAIN_POS &&
                       {{(WORD_W-POS_W){1'b0}}, seen_r} < exp_r) begin
            seen_nxt = seen_r + 1'b1;
            if (in_ch.word < limit_r && cnt_r < CNT_W'(MAX_STACK_DEPTH)) begin
              stk_wr.en = 1'b1;
              stk_wr.addr = cnt_r[STK_AW-1:0];
              stk_wr.data = in_ch.word;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end else if (class_r == CLASS_LOST && pos_r == LOST_POS) begin
          lost_nxt = lost_r + in_ch.word;
        end
        pos_nxt = pos_r + 1'b1;
        finish = ((pos_r + 1'b1) >= words_r);
      end
      // record end
      if (finish) begin
        pos_nxt = '0;
        if (class_nxt == CLASS_SAMPLE) begin
          samples_nxt = samples_r + 1'b1;
          if (words_nxt >= CHAIN_POS) begin
            if (cnt_nxt != '0) begin
              push_job.stack_cnt = cnt_nxt;
            end else if (ip_nxt != '0) begin
              push_job.ip_only = 1'b1;
            end
          end
        end
      end
      push_job.tot = in_ch.batch_end;
    end
    push_job.ip = ip_nxt;
    push_job.samples = samples_nxt;
    push_job.lost = lost_nxt;
  end

  assign push = accept && (push_job.err || push_job.tot || push_job.ip_only ||
                           (push_job.stack_cnt != '0));
  assign stack_push = push && (push_job.stack_cnt != '0);

  // count of stack jobs not yet drained by the back
  always_comb begin
    unique case ({stack_push, stack_done})
      2'b10:   busy_nxt = busy_r + 1'b1;
      2'b01:   busy_nxt = busy_r - 1'b1;
      default: busy_nxt = busy_r;
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_r <= 1'b0;
      pos_r <= '0;
      words_r <= '0;
      class_r <= CLASS_OTHER;
      ip_r <= '0;
      exp_r <= '0;
      seen_r <= '0;
      cnt_r <= '0;
      samples_r <= '0;
      lost_r <= '0;
      busy_r <= '0;
    end else begin
      discard_r <= discard_nxt;
      pos_r <= pos_nxt;
      words_r <= words_nxt;
      class_r <= class_nxt;
      ip_r <= ip_nxt;
      exp_r <= exp_nxt;
      seen_r <= seen_nxt;
      cnt_r <= cnt_nxt;
      samples_r <= samples_nxt;
      lost_r <= lost_nxt;
      busy_r <= busy_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CONTEXT_LIMIT_RST;
      max_r <= MAX_RECORD_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTEXT_LIMIT:    limit_r <= cfg_data;
        CFG_MAX_RECORD_BYTES: max_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/prrp_queue.sv -----
// prrp_queue: short job fifo between front and back
// depends on prrp_pkg

module prrp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prrp_pkg::job_t push_job,
  input  logic           pop,
  output prrp_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import prrp_pkg::*;

  job_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign head = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/prrp_back.sv -----
// prrp_back: takes jobs from the queue and sends their results, reading
// stack entries from the stack store; depends on prrp_pkg, prrp_if

module prrp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prrp_pkg::job_t              q_head,
  input  logic                        q_empty,
  output logic                        pop,
  output logic                        rd_en,
  output logic [prrp_pkg::STK_AW-1:0] rd_addr,
  input  logic [prrp_pkg::WORD_W-1:0] rd_data,
  output logic                        stack_done,
  prrp_out_if.source                  out_ch
);
  import prrp_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic                 out_valid_r;
  kind_e_t              kind_r;
  logic [WORD_W-1:0]    address_r;
  logic [DEPTH_W-1:0]   depth_r;
  logic                 last_r;
  logic [SAMPLES_W-1:0] samples_r;
  logic [WORD_W-1:0]    lost_r;

  logic              emit;
  logic              idx_last;
  back_state_t       first_state;
  back_state_t       tail_state;
  logic              out_load;
  kind_e_t           kind_nxt;
  logic [WORD_W-1:0] address_nxt;
  logic [DEPTH_W-1:0] depth_nxt;
  logic              last_nxt;

  assign emit = !out_valid_r || out_ch.ready;
  assign idx_last = (idx_r == job_r.stack_cnt - 1'b1);

  // first phase of a new job and what follows the address results
  always_comb begin
    priority if (q_head.stack_cnt != '0) begin
      first_state = BK_READ;
    end else if (q_head.ip_only) begin
      first_state = BK_IP;
    end else if (q_head.err) begin
      first_state = BK_ERR;
    end else begin
      first_state = BK_TOT;
    end
    priority if (job_r.err) begin
      tail_state = BK_ERR;
    end else if (job_r.tot) begin
      tail_state = BK_TOT;
    end else begin
      tail_state = BK_IDLE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = first_state;
        end
      end
      BK_READ: state_nxt = BK_STACK;
      BK_STACK: begin
        if (emit) begin
          state_nxt = idx_last ? tail_state : BK_READ;
        end
      end
      BK_IP: begin
        if (emit) begin
          state_nxt = tail_state;
        end
      end
      BK_ERR: begin
        if (emit) begin
          state_nxt = job_r.tot ? BK_TOT : BK_IDLE;
        end
      end
      BK_TOT: begin
        if (emit) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    pop = 1'b0;
    rd_en = 1'b0;
    stack_done = 1'b0;
    out_load = 1'b0;
    idx_nxt = idx_r;
    kind_nxt = KIND_TOTALS;
    address_nxt = '0;
    depth_nxt = '0;
    last_nxt = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        pop = !q_empty;
        idx_nxt = '0;
      end
      BK_READ: rd_en = 1'b1;
      BK_STACK: begin
        out_load = emit;
        kind_nxt = KIND_STACK;
        address_nxt = rd_data;
        depth_nxt = DEPTH_W'(idx_r);
        last_nxt = idx_last && !job_r.err && !job_r.tot;
        stack_done = emit && idx_last;
        if (emit && !idx_last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_IP: begin
        out_load = emit;
        kind_nxt = KIND_STACK;
        address_nxt = job_r.ip;
        last_nxt = !job_r.err && !job_r.tot;
      end
      BK_ERR: begin
        out_load = emit;
        kind_nxt = KIND_ERROR;
        last_nxt = !job_r.tot;
      end
      BK_TOT: out_load = emit;
      default: ;
    endcase
  end

  assign rd_addr = idx_r[STK_AW-1:0];

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end

  // current job
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r <= kind_nxt;
      address_r <= address_nxt;
      depth_r <= depth_nxt;
      last_r <= last_nxt;
      samples_r <= job_r.samples;
      lost_r <= job_r.lost;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = kind_r;
  assign out_ch.address = address_r;
  assign out_ch.depth_index = depth_r;
  assign out_ch.last = last_r;
  assign out_ch.samples_total = samples_r;
  assign out_ch.lost_total = lost_r;

endmodule

// ----- hw/rtl/perf_ring_record_parser_core.sv -----
// perf_ring_record_parser_core: one input word per cycle when the job queue has room
// and no stack job is queued or draining while a chain word arrives; the first result
// of a word passes through the job queue, the back and its output register, a stack
// also through a store read; the back sends one result per cycle while the port is ready,
// with a store read before each stack address and a pop per job from the four-entry queue
// synchronous active-low reset clears parser state, counters and queue and sets config to its reset values

module perf_ring_record_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  prrp_in_if.sink                        in_ch,
  prrp_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [prrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prrp_pkg::WORD_W-1:0]    cfg_data
);
  import prrp_pkg::*;

  logic              push;
  job_t              push_job;
  job_t              q_head;
  logic              q_empty;
  logic              q_full;
  logic              pop;
  stk_wr_t           stk_wr;
  logic              rd_en;
  logic [STK_AW-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              stack_done;

  prrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .stack_done (stack_done),
    .push       (push),
    .push_job   (push_job),
    .stk_wr     (stk_wr)
  );

  prrp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_wr.en),
    .waddr (stk_wr.addr),
    .wdata (stk_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  prrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  prrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .stack_done (stack_done),
    .out_ch     (out_ch)
  );

endmodule

// ----- hw/rtl/prrp_checker.sv -----
// prrp_checker: port-level assertions on the result channel, bound to the top
// depends on prrp_pkg and perf_ring_record_parser_core

module prrp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [prrp_pkg::KIND_W-1:0]      out_kind,
  input logic [prrp_pkg::WORD_W-1:0]      out_address,
  input logic [prrp_pkg::DEPTH_W-1:0]     out_depth_index,
  input logic                             out_last,
  input logic [prrp_pkg::SAMPLES_W-1:0]   out_samples_total,
  input logic [prrp_pkg::WORD_W-1:0]      out_lost_total
);
  import prrp_pkg::*;

  // a stalled transaction stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled transaction keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_address) &&
      $stable(out_depth_index) && $stable(out_last) &&
      $stable(out_samples_total) && $stable(out_lost_total))
    else $error("result payload changed while stalled");

  // totals always close the results of a word
  a_totals_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TOTALS |-> out_last)
    else $error("totals result not marked last");

  // only stack results carry an address and position
  a_nonstack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_STACK |-> out_address == '0 && out_depth_index == '0)
    else $error("address or depth on a non-stack result");

  // stack positions count up within one stack
  a_depth_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_STACK && !out_last ##1
      out_valid && out_kind == KIND_STACK |-> out_depth_index == $past(out_depth_index) + 1'b1)
    else $error("stack position out of order");

endmodule

bind perf_ring_record_parser_core prrp_checker u_prrp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_address       (out_ch.address),
  .out_depth_index   (out_ch.depth_index),
  .out_last          (out_ch.last),
  .out_samples_total (out_ch.samples_total),
  .out_lost_total    (out_ch.lost_total)
);
